FILE: rtl/sdes_pkg.sv
`timescale 1ns / 1ps

package sdes_pkg;

    localparam int FULL_SCALE = 1000;

    localparam int IN_W    = 12;
    localparam int DZ_W    = 10;
    localparam int EXPO_W  = 16;
    localparam int OUT_W   = 17;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 1;

    localparam int FRAC_BITS = 15;
    localparam int Q_W       = FRAC_BITS + 1;
    localparam int MAG_W     = $clog2(FULL_SCALE + 1);
    localparam int EXT_W     = ((IN_W > MAG_W) ? IN_W : MAG_W) + 2;

    localparam logic [Q_W-1:0] Q15_ONE = Q_W'(32'd1 << FRAC_BITS);

    localparam logic [IDX_W-1:0] REG_DEAD_ZONE   = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_EXPO_WEIGHT = IDX_W'(1);

    typedef struct packed {
        logic neg;
        logic zero;
    } t_side;

endpackage

FILE: rtl/sdes_div.sv
`timescale 1ns / 1ps

module sdes_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [sdes_pkg::MAG_W-1:0]     i_rem,
    input  logic [sdes_pkg::MAG_W-1:0]     i_den,
    input  logic [sdes_pkg::Q_W-1:0]       i_q,
    input  sdes_pkg::t_side                i_side,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [sdes_pkg::Q_W-1:0]       o_q,
    output sdes_pkg::t_side                o_side
);

    localparam int BPS    = 5;
    localparam int STAGES = (sdes_pkg::FRAC_BITS + BPS - 1) / BPS;
    localparam int MW     = sdes_pkg::MAG_W;
    localparam int QW     = sdes_pkg::Q_W;

    logic                r_vld  [STAGES];
    logic [MW-1:0]       r_rem  [STAGES];
    logic [MW-1:0]       r_den  [STAGES];
    logic [QW-1:0]       r_q    [STAGES];
    sdes_pkg::t_side     r_side [STAGES];
    logic                w_rdy  [STAGES];

    genvar s;
    generate
        for (s = 0; s < STAGES; s++) begin : g_stage
            logic            w_vin;
            logic [MW-1:0]   w_rin;
            logic [MW-1:0]   w_din;
            logic [QW-1:0]   w_qin;
            sdes_pkg::t_side w_sin;
            logic [MW-1:0]   n_rem;
            logic [QW-1:0]   n_q;

            if (s == 0) begin : g_first
                assign w_vin = i_valid;
                assign w_rin = i_rem;
                assign w_din = i_den;
                assign w_qin = i_q;
                assign w_sin = i_side;
            end else begin : g_next
                assign w_vin = r_vld[s-1];
                assign w_rin = r_rem[s-1];
                assign w_din = r_den[s-1];
                assign w_qin = r_q[s-1];
                assign w_sin = r_side[s-1];
            end

            if (s == STAGES - 1) begin : g_last_rdy
                assign w_rdy[s] = !r_vld[s] || i_ready;
            end else begin : g_mid_rdy
                assign w_rdy[s] = !r_vld[s] || w_rdy[s+1];
            end

            always_comb begin
                logic [MW:0] t;
                n_rem = w_rin;
                n_q   = w_qin;
                for (int j = 0; j < BPS; j++) begin
                    if (s * BPS + j < sdes_pkg::FRAC_BITS) begin
                        t = {n_rem, 1'b0};
                        if (t >= {1'b0, w_din}) begin
                            n_rem = MW'(t - {1'b0, w_din});
                            n_q   = {n_q[QW-2:0], 1'b1};
                        end else begin
                            n_rem = t[MW-1:0];
                            n_q   = {n_q[QW-2:0], 1'b0};
                        end
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else if (w_rdy[s]) begin
                    r_vld[s] <= w_vin;
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_rdy[s]) begin
                    r_rem[s]  <= n_rem;
                    r_den[s]  <= w_din;
                    r_q[s]    <= n_q;
                    r_side[s] <= w_sin;
                end
            end
        end
    endgenerate

    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[STAGES-1];
    assign o_q     = r_q[STAGES-1];
    assign o_side  = r_side[STAGES-1];

endmodule

FILE: rtl/stick_deadband_expo_shaper_core.sv
`timescale 1ns / 1ps
// channel   dir  handshake                  payload
// s_axis    in   i_s_axis_tvalid/o_..tready  tdata[11:0] stick_raw
// m_axis    out  o_m_axis_tvalid/i_..tready  tdata[16:0] shaped_out
// cfg       in   i_cfg_valid/o_cfg_ready     index 0 dead_zone, 1 expo_weight
//
// One word per cycle sustained while m_axis is ready; the path from s_axis accept to the
// earliest m_axis accept runs through prep, three 5-bit divider stages, three multiplier stages, output.
// Synchronous active-low reset clears all valid bits and the two registers.
// A stall on m_axis holds the output word and backs up stage by stage; bubbles
// close up, so s_axis stays ready while any stage ahead is empty.

module stick_deadband_expo_shaper_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [11:0] stick_raw
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [16:0] shaped_out
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [sdes_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [sdes_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int MW = sdes_pkg::MAG_W;
    localparam int QW = sdes_pkg::Q_W;
    localparam int EW = sdes_pkg::EXT_W;
    localparam int FB = sdes_pkg::FRAC_BITS;
    localparam logic signed [EW-1:0] FS_POS = EW'(sdes_pkg::FULL_SCALE);
    localparam logic signed [EW-1:0] FS_NEG = -EW'(sdes_pkg::FULL_SCALE);
    localparam logic [MW-1:0] FS_MAG = MW'(sdes_pkg::FULL_SCALE);
    localparam logic [MW-1:0] DB_MAX = MW'(sdes_pkg::FULL_SCALE - 1);

    logic [sdes_pkg::DZ_W-1:0]   r_dead_zone;
    logic [sdes_pkg::EXPO_W-1:0] r_expo_weight;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone   <= '0;
            r_expo_weight <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sdes_pkg::REG_DEAD_ZONE:   r_dead_zone   <= i_cfg_data[sdes_pkg::DZ_W-1:0];
                sdes_pkg::REG_EXPO_WEIGHT: r_expo_weight <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamped config
    logic [MW-1:0] w_db;
    logic [QW-1:0] w_e;
    logic [QW-1:0] w_one_m_e;

    always_comb begin
        if (32'(r_dead_zone) > 32'(DB_MAX)) begin
            w_db = DB_MAX;
        end else begin
            w_db = MW'(r_dead_zone);
        end
        if (r_expo_weight > sdes_pkg::Q15_ONE) begin
            w_e = sdes_pkg::Q15_ONE;
        end else begin
            w_e = r_expo_weight;
        end
        w_one_m_e = sdes_pkg::Q15_ONE - w_e;
    end

    // ready chain
    logic w_p_rdy, w_div_rdy, w_m1_rdy, w_m2_rdy, w_m3_rdy, w_out_rdy;
    logic r_p_vld, r_m1_vld, r_m2_vld, r_m3_vld, r_out_vld;
    logic w_d_vld;

    assign w_out_rdy = !r_out_vld || i_m_axis_tready;
    assign w_m3_rdy  = !r_m3_vld  || w_out_rdy;
    assign w_m2_rdy  = !r_m2_vld  || w_m3_rdy;
    assign w_m1_rdy  = !r_m1_vld  || w_m2_rdy;
    assign w_p_rdy   = !r_p_vld   || w_div_rdy;

    assign o_s_axis_tready = w_p_rdy;

    // prep: saturate, magnitude, dead zone, first quotient bit
    logic [MW-1:0]   r_p_rem, r_p_den, n_p_rem, n_p_den;
    logic [QW-1:0]   r_p_q, n_p_q;
    sdes_pkg::t_side r_p_side, n_p_side;

    always_comb begin
        logic signed [EW-1:0] x;
        logic signed [EW-1:0] a;
        logic [MW-1:0]        mag;
        logic [MW-1:0]        num;
        x = EW'($signed(i_s_axis_tdata[sdes_pkg::IN_W-1:0]));
        if (x > FS_POS) begin
            x = FS_POS;
        end else if (x < FS_NEG) begin
            x = FS_NEG;
        end
        n_p_side.neg = x < 0;
        a   = n_p_side.neg ? -x : x;
        mag = a[MW-1:0];
        n_p_side.zero = mag < w_db;
        num     = mag - w_db;
        n_p_den = FS_MAG - w_db;
        if (num >= n_p_den) begin
            n_p_q   = QW'(1);
            n_p_rem = num - n_p_den;
        end else begin
            n_p_q   = '0;
            n_p_rem = num;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (w_p_rdy) begin
            r_p_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_p_rdy) begin
            r_p_rem  <= n_p_rem;
            r_p_den  <= n_p_den;
            r_p_q    <= n_p_q;
            r_p_side <= n_p_side;
        end
    end

    // fraction m
    logic [QW-1:0]   w_d_q;
    sdes_pkg::t_side w_d_side;

    sdes_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p_vld),
        .o_ready (w_div_rdy),
        .i_rem   (r_p_rem),
        .i_den   (r_p_den),
        .i_q     (r_p_q),
        .i_side  (r_p_side),
        .o_valid (w_d_vld),
        .i_ready (w_m1_rdy),
        .o_q     (w_d_q),
        .o_side  (w_d_side)
    );

    // m1: m^2 and linear term
    logic [QW-1:0]   r_m1_m, r_m1_m2, r_m1_wl;
    sdes_pkg::t_side r_m1_side;
    logic [2*QW-1:0] w_p_mm, w_p_lin;

    assign w_p_mm  = (2*QW)'(w_d_q) * (2*QW)'(w_d_q);
    assign w_p_lin = (2*QW)'(w_one_m_e) * (2*QW)'(w_d_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
        end else if (w_m1_rdy) begin
            r_m1_vld <= w_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_m1_rdy) begin
            r_m1_m    <= w_d_q;
            r_m1_m2   <= w_p_mm[FB+QW-1:FB];
            r_m1_wl   <= w_p_lin[FB+QW-1:FB];
            r_m1_side <= w_d_side;
        end
    end

    // m2: m^3
    logic [QW-1:0]   r_m2_m3, r_m2_wl;
    sdes_pkg::t_side r_m2_side;
    logic [2*QW-1:0] w_p_m3;

    assign w_p_m3 = (2*QW)'(r_m1_m2) * (2*QW)'(r_m1_m);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_vld <= 1'b0;
        end else if (w_m2_rdy) begin
            r_m2_vld <= r_m1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_m2_rdy) begin
            r_m2_m3   <= w_p_m3[FB+QW-1:FB];
            r_m2_wl   <= r_m1_wl;
            r_m2_side <= r_m1_side;
        end
    end

    // m3: cubic term
    logic [QW-1:0]   r_m3_we, r_m3_wl;
    sdes_pkg::t_side r_m3_side;
    logic [2*QW-1:0] w_p_cub;

    assign w_p_cub = (2*QW)'(w_e) * (2*QW)'(r_m2_m3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m3_vld <= 1'b0;
        end else if (w_m3_rdy) begin
            r_m3_vld <= r_m2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_m3_rdy) begin
            r_m3_we   <= w_p_cub[FB+QW-1:FB];
            r_m3_wl   <= r_m2_wl;
            r_m3_side <= r_m2_side;
        end
    end

    // out: blend, cap, sign
    logic [sdes_pkg::OUT_W-1:0] r_out_data, n_out_data;

    always_comb begin
        logic [QW:0] sum;
        sum = {1'b0, r_m3_wl} + {1'b0, r_m3_we};
        if (sum > {1'b0, sdes_pkg::Q15_ONE}) begin
            sum = {1'b0, sdes_pkg::Q15_ONE};
        end
        if (r_m3_side.zero) begin
            n_out_data = '0;
        end else if (r_m3_side.neg) begin
            n_out_data = sdes_pkg::OUT_W'(-sum);
        end else begin
            n_out_data = sdes_pkg::OUT_W'(sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_rdy) begin
            r_out_vld <= r_m3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_rdy) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {(24 - sdes_pkg::OUT_W)'(0), r_out_data};

endmodule

FILE: rtl/sdes_chk.sv
`timescale 1ns / 1ps

module sdes_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [15:0] i_s_axis_tdata,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [sdes_pkg::IDX_W-1:0] i_cfg_index,
    input logic [sdes_pkg::CFG_W-1:0] i_cfg_data
);

    logic signed [sdes_pkg::OUT_W-1:0] w_res;
    assign w_res = $signed(o_m_axis_tdata[sdes_pkg::OUT_W-1:0]);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_res >= -17'sd32768) && (w_res <= 17'sd32768)
                            && (o_m_axis_tdata[23:sdes_pkg::OUT_W] == '0))
        else $error("result outside plus or minus one");

    a_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_axis_tvalid || i_m_axis_tready) |-> o_s_axis_tready)
        else $error("input blocked while output drains");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled output word changed");

endmodule

bind stick_deadband_expo_shaper_core sdes_chk u_sdes_chk (.*);

FILE: tb/stick_deadband_expo_shaper_core_test.sv
`timescale 1ns / 1ps

module stick_deadband_expo_shaper_core_test;

    localparam longint unsigned Q15_UNIT = 64'd32768;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 190;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_s_axis_tvalid = 1'b0;
    logic                            o_s_axis_tready;
    logic [15:0]                     i_s_axis_tdata = '0;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready = 1'b0;
    logic [23:0]                     o_m_axis_tdata;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [sdes_pkg::IDX_W-1:0]      i_cfg_index = '0;
    logic [sdes_pkg::CFG_W-1:0]      i_cfg_data = '0;

    logic [sdes_pkg::IN_W-1:0]   stick_queue[$];
    logic [sdes_pkg::OUT_W-1:0]  shaped_queue[$];
    logic [sdes_pkg::DZ_W-1:0]   dz_copy = '0;
    logic [sdes_pkg::EXPO_W-1:0] expo_copy = '0;
    logic [sdes_pkg::OUT_W-1:0]  want_shaped;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                fail_count = 0;
    int                cycle_count = 0;

    int reset_sticks[13] = '{-2048, 2047, 1000, 1001, -1000, -1001, 0, 1, -1,
                             999, -999, 500, -500};
    int mid_sticks[7]    = '{99, 100, 101, -99, -100, -101, 0};
    int wide_sticks[6]   = '{998, 999, 1000, -999, 0, 2047};

    stick_deadband_expo_shaper_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [sdes_pkg::OUT_W-1:0] shape_stick(
            logic [sdes_pkg::IN_W-1:0] raw,
            logic [sdes_pkg::DZ_W-1:0] dz,
            logic [sdes_pkg::EXPO_W-1:0] ew);
        int r;
        logic neg;
        longint unsigned mag, db, e, frac, sq, cube, curve;
        logic [sdes_pkg::OUT_W-1:0] res;
        r = $signed(raw);
        if (r > sdes_pkg::FULL_SCALE) r = sdes_pkg::FULL_SCALE;
        if (r < -sdes_pkg::FULL_SCALE) r = -sdes_pkg::FULL_SCALE;
        neg = (r < 0);
        mag = neg ? -r : r;
        db = dz;
        if (db > sdes_pkg::FULL_SCALE - 1) db = sdes_pkg::FULL_SCALE - 1;
        e = ew;
        if (e > Q15_UNIT) e = Q15_UNIT;
        if (mag < db) return '0;
        frac = ((mag - db) << sdes_pkg::FRAC_BITS) / (sdes_pkg::FULL_SCALE - db);
        if (frac > Q15_UNIT) frac = Q15_UNIT;
        sq = (frac * frac) >> sdes_pkg::FRAC_BITS;
        cube = (sq * frac) >> sdes_pkg::FRAC_BITS;
        curve = (((Q15_UNIT - e) * frac) >> sdes_pkg::FRAC_BITS)
                + ((e * cube) >> sdes_pkg::FRAC_BITS);
        if (curve > Q15_UNIT) curve = Q15_UNIT;
        res = curve[sdes_pkg::OUT_W-1:0];
        if (neg) res = -res;
        return res;
    endfunction

    // favor the dead zone edge, full scale edge and the small range
    function automatic logic [sdes_pkg::IN_W-1:0] pick_stick();
        int db;
        int v;
        db = (dz_copy > sdes_pkg::FULL_SCALE - 1) ? sdes_pkg::FULL_SCALE - 1
                                                   : int'(dz_copy);
        case ($urandom_range(4))
            0: return sdes_pkg::IN_W'($urandom);
            1: v = db + int'($urandom_range(4)) - 2;
            2: v = sdes_pkg::FULL_SCALE + int'($urandom_range(4)) - 2;
            3: v = int'($urandom_range(2 * sdes_pkg::FULL_SCALE)) - sdes_pkg::FULL_SCALE;
            default: v = int'($urandom_range(16)) - 8;
        endcase
        if ($urandom_range(1) == 1) v = -v;
        return sdes_pkg::IN_W'(v);
    endfunction

    // stick driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (stick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= {4'b0, stick_queue.pop_front()};
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // check results, then predict newly accepted sticks
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dz_copy   = '0;
            expo_copy = '0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (shaped_queue.size() == 0) begin
                    $error("shaped_out: no word expected, got %0d",
                           $signed(o_m_axis_tdata[sdes_pkg::OUT_W-1:0]));
                    fail_count++;
                end else begin
                    want_shaped = shaped_queue.pop_front();
                    if (o_m_axis_tdata[sdes_pkg::OUT_W-1:0] !== want_shaped) begin
                        $error("shaped_out: expected %0d, got %0d", $signed(want_shaped),
                               $signed(o_m_axis_tdata[sdes_pkg::OUT_W-1:0]));
                        fail_count++;
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                shaped_queue.push_back(shape_stick(i_s_axis_tdata[sdes_pkg::IN_W-1:0],
                                                   dz_copy, expo_copy));
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    sdes_pkg::REG_DEAD_ZONE:
                        dz_copy   = i_cfg_data[sdes_pkg::DZ_W-1:0];
                    sdes_pkg::REG_EXPO_WEIGHT:
                        expo_copy = i_cfg_data[sdes_pkg::EXPO_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("stick_deadband_expo_shaper_core verification failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [sdes_pkg::IDX_W-1:0] idx,
                             input logic [sdes_pkg::CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input logic [sdes_pkg::CFG_W-1:0] dz,
                            input logic [sdes_pkg::CFG_W-1:0] ew);
        write_reg(sdes_pkg::REG_DEAD_ZONE, dz);
        write_reg(sdes_pkg::REG_EXPO_WEIGHT, ew);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (stick_queue.size() != 0 || i_s_axis_tvalid || shaped_queue.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic feed_random(input int count);
        for (int i = 0; i < count; i++) stick_queue.push_back(pick_stick());
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (reset_sticks[i]) stick_queue.push_back(sdes_pkg::IN_W'(reset_sticks[i]));
        wait_drained();
        set_regs(16'd100, 16'd16384);
        foreach (mid_sticks[i]) stick_queue.push_back(sdes_pkg::IN_W'(mid_sticks[i]));
        wait_drained();
        set_regs(16'hFFFF, 16'hFFFF);
        foreach (wide_sticks[i]) stick_queue.push_back(sdes_pkg::IN_W'(wide_sticks[i]));
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    set_regs(16'd0, 16'd0);
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                1: begin
                    set_regs(sdes_pkg::CFG_W'($urandom_range(999)),
                             sdes_pkg::CFG_W'($urandom_range(32768)));
                    send_idle_pct = 57; recv_stall_pct = 0;
                end
                2: begin
                    set_regs(sdes_pkg::CFG_W'($urandom), sdes_pkg::CFG_W'($urandom));
                    send_idle_pct = 0;  recv_stall_pct = 57;
                end
                3: begin
                    set_regs(16'd999, 16'd32768);
                    send_idle_pct = 32; recv_stall_pct = 32;
                end
                4: begin
                    set_regs(sdes_pkg::CFG_W'($urandom_range(50)),
                             sdes_pkg::CFG_W'($urandom_range(65535, 32768)));
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                default: begin
                    set_regs(sdes_pkg::CFG_W'($urandom_range(999)),
                             sdes_pkg::CFG_W'($urandom_range(32768)));
                    send_idle_pct = 32; recv_stall_pct = 32;
                end
            endcase
            // hold the sender until the pipe drains halfway through
            feed_random(PHASE_ITEMS / 2);
            wait_drained();
            feed_random(PHASE_ITEMS - PHASE_ITEMS / 2);
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && shaped_queue.size() == 0) begin
            $display("stick_deadband_expo_shaper_core verification clean");
        end else begin
            $display("stick_deadband_expo_shaper_core verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/sdes_pkg.sv
rtl/sdes_div.sv
rtl/stick_deadband_expo_shaper_core.sv
rtl/sdes_chk.sv
tb/stick_deadband_expo_shaper_core_test.sv
